// ----- hw/rtl/grs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package grs_pkg;

	// Width of the group size register.
	localparam int unsigned CFG_W = 5;

	typedef enum logic {
		ST_COLLECT,
		ST_DRAIN
	} grs_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/grs_stream_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface grs_elem_if #(
	parameter int unsigned W = 32
);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] element_value;
	logic                is_final;

	modport source (output valid, output element_value, output is_final, input ready);
	modport sink (input valid, input element_value, input is_final, output ready);
endinterface

interface grs_result_if #(
	parameter int unsigned W = 32
);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] out_value;
	logic                run_last;
	logic                list_last;

	modport source (output valid, output out_value, output run_last, output list_last,
		input ready);
	modport sink (input valid, input out_value, input run_last, input list_last,
		output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/grs_group_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none

module grs_group_mem
	import grs_pkg::*;
#(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned W     = 32,
	parameter int unsigned AW    = 4
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [W-1:0]  wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [W-1:0]  rd_data_s1
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// The read register holds its value while the consumer stalls.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/group_reverse_stream_core.sv -----
// Reverses a stream of list elements in groups of group_size (1 to MAX_GROUP; zero acts
// as one, larger values saturate). Elements are written one per cycle into a group
// memory. When a group fills, or the element flagged is_final arrives, the input stalls
// and the buffered elements are read back, one per cycle while results are taken, through
// the memory's single read port: newest first for a full group, in arrival order for a
// short trailing group. No new element is taken until the last read of a group has been
// issued, and each result comes from the memory's registered read port. run_last marks
// the final result of each group and list_last the final result of the list. No clearing
// pass is needed after reset; group_size may only be written while no group is being
// emitted.
`timescale 1ns / 1ps
`default_nettype none

module group_reverse_stream_core
	import grs_pkg::*;
#(
	parameter int unsigned MAX_GROUP     = 16,
	parameter int unsigned ELEMENT_WIDTH = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             group_size_we,
	input  wire logic [CFG_W-1:0] group_size_wdata,
	grs_elem_if.sink              elem,
	grs_result_if.source          result
);

	localparam int unsigned CNT_W = $clog2(MAX_GROUP + 1);
	localparam int unsigned IDX_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
	localparam int unsigned SZ_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	grs_state_t         state_q, state_d;
	logic [CFG_W-1:0]   group_size_q;
	logic [CNT_W-1:0]   fill_q;
	logic [CNT_W-1:0]   left_q;
	logic [IDX_W-1:0]   rd_idx_q;
	logic               rev_q;
	logic               fin_q;
	logic               v_s1;
	logic               run_last_s1;
	logic               list_last_s1;

	logic [SZ_W-1:0]    size_ext;
	logic [CNT_W-1:0]   eff_size;
	logic               in_xfer;
	logic               wr_en;
	logic [CNT_W-1:0]   fill_next;
	logic               full;
	logic               trigger;
	logic               issue;
	logic               issue_last;
	logic [ELEMENT_WIDTH-1:0] rd_data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_size_q <= CFG_W'(1);
		end else if (group_size_we) begin
			group_size_q <= group_size_wdata;
		end
	end

	always_comb begin
		size_ext = SZ_W'(group_size_q);
		if (group_size_q == '0) begin
			eff_size = CNT_W'(1);
		end else if (size_ext > SZ_W'(MAX_GROUP)) begin
			eff_size = CNT_W'(MAX_GROUP);
		end else begin
			eff_size = CNT_W'(size_ext);
		end
	end

	assign in_xfer   = elem.valid && elem.ready;
	assign wr_en     = in_xfer && (fill_q < CNT_W'(MAX_GROUP));
	assign fill_next = wr_en ? (fill_q + CNT_W'(1)) : fill_q;
	assign full      = fill_next >= eff_size;
	assign trigger   = in_xfer && (full || elem.is_final);

	// In the drain state, a read may start whenever the result register is empty or being emptied.
	assign issue_last = (left_q == CNT_W'(1));

	always_comb begin
		state_d    = state_q;
		elem.ready = 1'b0;
		issue      = 1'b0;
		case (state_q)
			ST_COLLECT: begin
				elem.ready = 1'b1;
				if (trigger) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				issue = !v_s1 || result.ready;
				if (issue && issue_last) begin
					state_d = ST_COLLECT;
				end
			end
			default: begin
				state_d = ST_COLLECT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COLLECT;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			left_q   <= '0;
			rd_idx_q <= '0;
			rev_q    <= 1'b0;
			fin_q    <= 1'b0;
		end else if (trigger) begin
			// A full group starts at the entry just written and walks down.
			fill_q   <= fill_next;
			left_q   <= fill_next;
			rd_idx_q <= full ? fill_q[IDX_W-1:0] : '0;
			rev_q    <= full;
			fin_q    <= elem.is_final;
		end else if (in_xfer) begin
			fill_q <= fill_next;
		end else if (issue) begin
			left_q   <= left_q - CNT_W'(1);
			rd_idx_q <= rev_q ? (rd_idx_q - IDX_W'(1)) : (rd_idx_q + IDX_W'(1));
			if (issue_last) begin
				fill_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (issue) begin
			v_s1 <= 1'b1;
		end else if (result.ready) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			run_last_s1  <= issue_last;
			list_last_s1 <= issue_last && fin_q;
		end
	end

	grs_group_mem #(
		.DEPTH (MAX_GROUP),
		.W     (ELEMENT_WIDTH),
		.AW    (IDX_W)
	) u_mem (
		.clk        (clk),
		.wr_en      (wr_en),
		.wr_addr    (fill_q[IDX_W-1:0]),
		.wr_data    (elem.element_value),
		.rd_en      (issue),
		.rd_addr    (rd_idx_q),
		.rd_data_s1 (rd_data_s1)
	);

	assign result.valid     = v_s1;
	assign result.out_value = rd_data_s1;
	assign result.run_last  = run_last_s1;
	assign result.list_last = list_last_s1;

`ifndef NO_ASSERTIONS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(MAX_GROUP))
		else $error("group fill count exceeds the buffer depth");

	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> (left_q != '0))
		else $error("draining with no elements left");

	a_drain_done: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && issue_last) |=> ((state_q == ST_COLLECT) && (fill_q == '0)))
		else $error("group not released after its last read");

	a_list_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.list_last) |-> result.run_last)
		else $error("list end flagged on a result that does not end its group");
`endif

endmodule

`default_nettype wire

// ----- dv/group_reverse_stream_core_tb.sv -----
`timescale 1ns / 1ps

module group_reverse_stream_core_tb;
	import grs_pkg::*;

	localparam int unsigned GROUP_MAX        = 16;
	localparam int unsigned VAL_W            = 32;
	localparam int unsigned CYCLE_LIMIT      = 200000;
	localparam int unsigned SETTLE_CYCLES    = 40;
	localparam int unsigned LONG_HOLD_CYCLES = 300;
	localparam int unsigned LONG_HOLD_AFTER  = 80;
	localparam int unsigned RANDOM_PHASES    = 12;
	localparam int unsigned PHASE_ELEMS      = 34;

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic                    is_final;
	} list_elem_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic                    run_last;
		logic                    list_last;
	} reordered_elem_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             group_size_we;
	logic [CFG_W-1:0] group_size_wdata;

	grs_elem_if #(.W(VAL_W)) elem ();
	grs_result_if #(.W(VAL_W)) result ();

	group_reverse_stream_core #(
		.MAX_GROUP     (GROUP_MAX),
		.ELEMENT_WIDTH (VAL_W)
	) dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.group_size_we    (group_size_we),
		.group_size_wdata (group_size_wdata),
		.elem             (elem),
		.result           (result)
	);

	always #6 clk = ~clk;

	list_elem_t              pending_elems[$];
	reordered_elem_t         reordered_expect[$];
	logic signed [VAL_W-1:0] group_mem [GROUP_MAX];
	int unsigned             group_fill;
	logic [CFG_W-1:0]        size_shadow;

	int unsigned mismatches;
	int unsigned results_seen;
	int unsigned elems_seen;
	int unsigned lists_closed;
	int unsigned size_writes;
	int unsigned send_gap_pct;
	int unsigned recv_stall_pct;
	int unsigned cycle_count;

	function automatic int unsigned active_group_size(input logic [CFG_W-1:0] s);
		if (s == '0)
			return 1;
		if (s > GROUP_MAX)
			return GROUP_MAX;
		return 32'(s);
	endfunction

	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(9, 0))
			0: return {1'b1, {(VAL_W-1){1'b0}}};
			1: return {1'b0, {(VAL_W-1){1'b1}}};
			2: return '0;
			3: return '1;
			default: return VAL_W'($urandom);
		endcase
	endfunction

	// Collects one element and, when a group completes or the list ends, queues the
	// reordered group: newest first for a full group, arrival order for a short tail.
	task automatic reverse_groups(input logic signed [VAL_W-1:0] v, input logic fin);
		int              n;
		bit              full;
		reordered_elem_t o;
		if (group_fill < GROUP_MAX) begin
			group_mem[group_fill] = v;
			group_fill++;
		end
		full = group_fill >= active_group_size(size_shadow);
		if (full || fin) begin
			n = group_fill;
			for (int k = 0; k < n; k++) begin
				o.value     = group_mem[full ? n - 1 - k : k];
				o.run_last  = (k + 1 == n);
				o.list_last = (k + 1 == n) && fin;
				reordered_expect = {reordered_expect, o};
			end
			group_fill = 0;
			if (fin)
				lists_closed++;
		end
	endtask

	// Element driver.
	int unsigned send_gap = 0;
	always @(posedge clk) begin : elem_driver
		list_elem_t next_item;
		if (!elem.valid || elem.ready) begin
			if (send_gap != 0) begin
				send_gap--;
				elem.valid <= 1'b0;
			end else if (send_gap_pct != 0 && $urandom_range(99, 0) < send_gap_pct) begin
				send_gap = $urandom_range(4, 0);
				elem.valid <= 1'b0;
			end else if (pending_elems.size() != 0) begin
				next_item = pending_elems.pop_front();
				elem.valid         <= 1'b1;
				elem.element_value <= next_item.value;
				elem.is_final      <= next_item.is_final;
			end else begin
				elem.valid <= 1'b0;
			end
		end
	end

	// Result receiver. After a fixed number of element transfers it holds off once for a
	// long stretch so that the drain of a group stalls and the input stalls with it.
	int unsigned rx_elem_count = 0;
	int unsigned long_hold_left = 0;
	bit          long_hold_done = 1'b0;
	int unsigned recv_gap = 0;
	always @(posedge clk) begin : result_receiver
		if (arst_n && elem.valid && elem.ready)
			rx_elem_count++;
		if (!long_hold_done && rx_elem_count >= LONG_HOLD_AFTER) begin
			long_hold_done = 1'b1;
			long_hold_left = LONG_HOLD_CYCLES;
		end
		if (long_hold_left != 0) begin
			long_hold_left--;
			result.ready <= 1'b0;
		end else if (recv_gap != 0) begin
			recv_gap--;
			result.ready <= 1'b0;
		end else if (recv_stall_pct != 0 && $urandom_range(99, 0) < recv_stall_pct) begin
			recv_gap = $urandom_range(4, 0);
			result.ready <= 1'b0;
		end else begin
			result.ready <= 1'b1;
		end
	end

	// Monitor: predicts from element transfers first, then checks result transfers.
	always @(posedge clk) begin : transfer_monitor
		reordered_elem_t want;
		if (arst_n) begin
			if (elem.valid && elem.ready) begin
				elems_seen++;
				reverse_groups(elem.element_value, elem.is_final);
			end
			if (result.valid && result.ready) begin
				results_seen++;
				if (reordered_expect.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected result %0d: value %0d run_last %0b list_last %0b",
							results_seen, result.out_value, result.run_last, result.list_last);
				end else begin
					want = reordered_expect.pop_front();
					if (result.out_value !== want.value || result.run_last !== want.run_last
							|| result.list_last !== want.list_last) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"Result %0d mismatch: expected value %0d run_last %0b ",
								"list_last %0b, got value %0d run_last %0b list_last %0b"},
								results_seen, want.value, want.run_last, want.list_last,
								result.out_value, result.run_last, result.list_last);
					end
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding.",
				cycle_count, reordered_expect.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic write_group_size(input logic [CFG_W-1:0] s);
		@(posedge clk);
		group_size_we    <= 1'b1;
		group_size_wdata <= s;
		size_shadow = s;
		size_writes++;
		@(posedge clk);
		group_size_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send_elem(input logic signed [VAL_W-1:0] v, input logic fin);
		list_elem_t e;
		e.value    = v;
		e.is_final = fin;
		pending_elems = {pending_elems, e};
	endtask

	// Waits until every element has gone in and every result has come out, then gives
	// the block time to return to collecting.
	task automatic drain_and_settle();
		do
			@(negedge clk);
		while (pending_elems.size() != 0 || elem.valid || reordered_expect.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int unsigned      list_left;
		logic [CFG_W-1:0] sz;
		logic             fin;
		arst_n             = 1'b0;
		group_size_we      = 1'b0;
		group_size_wdata   = '0;
		elem.valid         = 1'b0;
		elem.element_value = '0;
		elem.is_final      = 1'b0;
		result.ready       = 1'b0;
		size_shadow        = 5'd1;
		group_fill         = 0;
		mismatches         = 0;
		results_seen       = 0;
		elems_seen         = 0;
		lists_closed       = 0;
		size_writes        = 0;
		cycle_count        = 0;
		send_gap_pct       = 25;
		recv_stall_pct     = 25;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Size one with the value extremes; the list ends on a single-element group.
		write_group_size(5'd1);
		send_elem({1'b0, {(VAL_W-1){1'b1}}}, 1'b0);
		send_elem({1'b1, {(VAL_W-1){1'b0}}}, 1'b1);
		drain_and_settle();

		// A size of zero acts as one.
		write_group_size(5'd0);
		send_elem('1, 1'b1);
		drain_and_settle();

		// Four elements wait in a group of eight, then the size drops to three, so the next
		// element flushes all five reversed. A full group and a short final tail follow.
		write_group_size(5'd8);
		for (int i = 1; i <= 4; i++)
			send_elem(i, 1'b0);
		drain_and_settle();
		write_group_size(5'd3);
		for (int i = 5; i <= 8; i++)
			send_elem(i, 1'b0);
		send_elem(9, 1'b0);
		send_elem(0, 1'b1);
		drain_and_settle();

		// An oversized setting saturates to sixteen; the list ends on a full group.
		write_group_size(5'd31);
		for (int i = 0; i < 16; i++)
			send_elem(pick_value(), i == 15);
		drain_and_settle();

		list_left = 0;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: sz = 5'd16;
				1: sz = 5'd1;
				2: sz = 5'd0;
				3: sz = 5'd31;
				7: sz = CFG_W'($urandom_range(30, 17));
				default: sz = CFG_W'($urandom_range(16, 1));
			endcase
			if (ph == RANDOM_PHASES - 1) begin
				send_gap_pct   = 0;
				recv_stall_pct = 0;
			end else begin
				send_gap_pct   = $urandom_range(2, 0) * 20;
				recv_stall_pct = $urandom_range(2, 0) * 20;
			end
			// Lists carry over from one setting to the next, so a change of size often
			// lands in the middle of a group.
			write_group_size(sz);
			for (int i = 0; i < PHASE_ELEMS; i++) begin
				if (list_left == 0) begin
					if ($urandom_range(3, 0) == 0)
						list_left = active_group_size(sz) * $urandom_range(3, 1);
					else
						list_left = $urandom_range(3 * active_group_size(sz), 1);
				end
				list_left--;
				fin = (list_left == 0) || (ph == RANDOM_PHASES - 1 && i == PHASE_ELEMS - 1);
				if (fin)
					list_left = 0;
				send_elem(pick_value(), fin);
			end
			drain_and_settle();
		end

		$display("Sent %0d elements in %0d closed lists, checked %0d results, %0d mismatches.",
			elems_seen, lists_closed, results_seen, mismatches);
		$display({"Covered %0d group size writes incl. 0, 1, 16, 31, a mid-group shrink ",
			"and a %0d-cycle hold-off."}, size_writes, LONG_HOLD_CYCLES);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
